FILE: sv/ftvp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_pkg
// Types and constants shared by the tag=value parser modules.
// ----------------------------------------------------------------------------
package ftvp_pkg;

	localparam int unsigned TAG_W   = 20;
	localparam int unsigned PROD_W  = TAG_W + 4;
	localparam int unsigned FTAG_W  = TAG_W + 1;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = QPTR_W + 1;

	localparam logic [PROD_W-1:0] TAG_LIMIT = PROD_W'(999999);
	localparam logic [TAG_W-1:0]  TAG_SAT   = TAG_W'(999999 + 1);

	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [TAG_W-1:0] TAG_BEGIN  = TAG_W'(8);
	localparam logic [TAG_W-1:0] TAG_LENGTH = TAG_W'(9);
	localparam logic [TAG_W-1:0] TAG_TYPE   = TAG_W'(35);

	localparam logic [1:0] KIND_VALUE   = 2'd0;
	localparam logic [1:0] KIND_FIELD   = 2'd1;
	localparam logic [1:0] KIND_MESSAGE = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_LIMIT     = 2'd2;

	typedef enum logic [6:0] {
		PH_START  = 7'b0000001,
		PH_SPACE  = 7'b0000010,
		PH_SIGN   = 7'b0000100,
		PH_DIGITS = 7'b0001000,
		PH_IGNORE = 7'b0010000,
		PH_VALUE  = 7'b0100000,
		PH_SKIP   = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [TAG_W-1:0]  tag_mag;
		logic              tag_neg;
		logic [1:0]        tag_bad;
		logic [7:0]        value_first;
		logic              value_nonempty;
		logic              seen_begin;
		logic              seen_length;
		logic              seen_type;
		logic [7:0]        type_reg;
		logic [1:0]        err;
	} state_t;

	localparam state_t STATE_IDLE = '{
		phase:          PH_START,
		tag_mag:        '0,
		tag_neg:        1'b0,
		tag_bad:        ERR_NONE,
		value_first:    8'h00,
		value_nonempty: 1'b0,
		seen_begin:     1'b0,
		seen_length:    1'b0,
		seen_type:      1'b0,
		type_reg:       8'h00,
		err:            ERR_NONE
	};

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [FTAG_W-1:0] field_tag;
		logic [7:0]               value_byte;
		logic                     message_valid;
		logic [7:0]               message_type;
		logic [1:0]               error_code;
		logic                     tail_dropped;
		logic                     run_last;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/ftvp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_step
// Next-state and result logic for one message byte.
// ----------------------------------------------------------------------------
module ftvp_step import ftvp_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output state_t     nxt,
	output result_t    res0,
	output result_t    res1,
	output logic [1:0] res_count
);

	logic                     is_eq;
	logic                     is_soh;
	logic                     is_space;
	logic                     is_sign;
	logic                     is_digit;
	logic [PROD_W-1:0]        prod;
	logic                     over;
	logic [TAG_W-1:0]         mag_d;
	logic signed [FTAG_W-1:0] tag_val;
	state_t                   mid;
	result_t                  fld;
	result_t                  msg;
	logic                     fld_v;

	assign is_eq    = (data_byte == CH_EQUAL);
	assign is_soh   = (data_byte == CH_SOH);
	assign is_space = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
	assign is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

	// mag*10 + digit, saturating just past the limit
	assign prod  = {1'b0, cur.tag_mag, 3'b000} + {3'b000, cur.tag_mag, 1'b0}
	             + {{(PROD_W-4){1'b0}}, data_byte[3:0]};
	assign over  = (prod > TAG_LIMIT);
	assign mag_d = over ? TAG_SAT : prod[TAG_W-1:0];

	assign tag_val = cur.tag_neg ? -$signed({1'b0, cur.tag_mag}) : $signed({1'b0, cur.tag_mag});

	always_comb begin
		mid   = cur;
		fld_v = 1'b0;
		fld   = '0;
		unique case (cur.phase)
			PH_START, PH_SPACE: begin
				if (is_eq) begin
					mid.tag_bad = ERR_MALFORMED;
					mid.phase   = PH_VALUE;
				end else if (is_space) begin
					mid.phase = PH_SPACE;
				end else if (is_sign) begin
					mid.tag_neg = (data_byte == CH_MINUS);
					mid.phase   = PH_SIGN;
				end else if (is_digit) begin
					mid.tag_mag = mag_d;
					if (over) mid.tag_bad = ERR_LIMIT;
					mid.phase = PH_DIGITS;
				end else begin
					mid.tag_bad = ERR_MALFORMED;
					mid.phase   = PH_IGNORE;
				end
			end
			PH_SIGN: begin
				if (is_eq) begin
					mid.tag_bad = ERR_MALFORMED;
					mid.phase   = PH_VALUE;
				end else if (is_digit) begin
					mid.tag_mag = mag_d;
					if (over) mid.tag_bad = ERR_LIMIT;
					mid.phase = PH_DIGITS;
				end else begin
					mid.tag_bad = ERR_MALFORMED;
					mid.phase   = PH_IGNORE;
				end
			end
			PH_DIGITS: begin
				if (is_eq) begin
					mid.phase = PH_VALUE;
				end else if (is_digit) begin
					mid.tag_mag = mag_d;
					if (over) mid.tag_bad = ERR_LIMIT;
				end else begin
					mid.phase = PH_IGNORE;
				end
			end
			PH_IGNORE: begin
				if (is_eq) mid.phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (is_soh) begin
					fld_v          = 1'b1;
					fld.kind       = KIND_FIELD;
					if (cur.tag_bad != ERR_NONE) begin
						mid.err = cur.tag_bad;
					end else begin
						fld.field_tag = tag_val;
						if (!cur.tag_neg && cur.tag_mag == TAG_BEGIN) mid.seen_begin = 1'b1;
						if (!cur.tag_neg && cur.tag_mag == TAG_LENGTH) mid.seen_length = 1'b1;
						if (!cur.tag_neg && cur.tag_mag == TAG_TYPE) begin
							mid.seen_type = 1'b1;
							if (cur.value_nonempty) mid.type_reg = cur.value_first;
						end
					end
					// close the field
					mid.tag_mag        = '0;
					mid.tag_neg        = 1'b0;
					mid.tag_bad        = ERR_NONE;
					mid.value_first    = '0;
					mid.value_nonempty = 1'b0;
					mid.phase          = (mid.err != ERR_NONE) ? PH_SKIP : PH_START;
				end else begin
					if (!cur.value_nonempty) begin
						mid.value_first    = data_byte;
						mid.value_nonempty = 1'b1;
					end
					if (cur.tag_bad == ERR_NONE) begin
						fld_v          = 1'b1;
						fld.kind       = KIND_VALUE;
						fld.field_tag  = tag_val;
						fld.value_byte = data_byte;
					end
				end
			end
			default: begin
				mid.phase = PH_SKIP;
			end
		endcase
		fld.message_type = mid.type_reg;
		fld.error_code   = mid.err;
		fld.run_last     = !end_of_message;
	end

	always_comb begin
		msg               = '0;
		msg.kind          = KIND_MESSAGE;
		msg.message_valid = (mid.err == ERR_NONE) && mid.seen_begin && mid.seen_length
		                  && mid.seen_type;
		msg.message_type  = mid.type_reg;
		msg.error_code    = mid.err;
		msg.tail_dropped  = (mid.phase != PH_START) && (mid.phase != PH_SKIP);
		msg.run_last      = 1'b1;

		nxt = mid;
		if (end_of_message) begin
			nxt                = '0;
			nxt.phase          = PH_START;
			nxt.type_reg       = mid.type_reg;
		end
	end

	assign res0      = fld_v ? fld : msg;
	assign res1      = msg;
	assign res_count = {1'b0, fld_v} + {1'b0, end_of_message};

endmodule
`default_nettype wire

FILE: sv/ftvp_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_outq
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ftvp_outq import ftvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  result_t    push0,
	input  result_t    push1,
	output logic       room2,
	output logic       head_valid,
	output result_t    head,
	input  logic       pop
);

	result_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_ptr1;

	assign wr_ptr1    = wr_ptr_q + QPTR_W'(1);
	assign room2      = (count_q <= QCNT_W'(QDEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) entry_q[wr_ptr_q] <= push0;
		if (push_count == 2'd2) entry_q[wr_ptr1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_count);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push_count) - QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: sv/fix_tag_value_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fix_tag_value_parser
// Splits a byte stream into tag=value fields ended by SOH.
// ----------------------------------------------------------------------------
// Input channel: one message byte per beat on data_byte, with end_of_message
// high on the last byte. A beat moves on a clock edge with byte_valid high and
// byte_stall low.
// Output channel: result beats (value byte, field complete, message complete)
// on result_valid / result_stall; run_last marks the final result of a byte.
// Each byte produces zero, one or two results. The parser state updates in the
// cycle the byte is taken and the results are registered into a four-entry queue;
// they reach the output once the results queued ahead of them have drained.
// Throughput: one byte per cycle while the queue has room for two results;
// the single output port drains one result per cycle while result_stall is low,
// so two-result bytes (a value or field beat plus message complete) build up.
// byte_stall rises when fewer than two queue entries are free, which happens
// only when the receiver holds result_stall high or two-result bytes pile up.
// Reset clears the parser state, the message type and the queue.
// ----------------------------------------------------------------------------
module fix_tag_value_parser import ftvp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  logic [7:0]               data_byte,
	input  logic                     end_of_message,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [1:0]               kind,
	output logic signed [FTAG_W-1:0] field_tag,
	output logic [7:0]               value_byte,
	output logic                     message_valid,
	output logic [7:0]               message_type,
	output logic [1:0]               error_code,
	output logic                     tail_dropped,
	output logic                     run_last
);

	state_t     state_q;
	state_t     state_nxt;
	result_t    res0;
	result_t    res1;
	result_t    head;
	logic [1:0] res_count;
	logic       room2;
	logic       take;

	assign byte_stall = !room2;
	assign take       = byte_valid && room2;

	ftvp_step u_step (
		.cur            (state_q),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.nxt            (state_nxt),
		.res0           (res0),
		.res1           (res1),
		.res_count      (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	ftvp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (take ? res_count : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.room2      (room2),
		.head_valid (result_valid),
		.head       (head),
		.pop        (result_valid && !result_stall)
	);

	assign kind          = head.kind;
	assign field_tag     = head.field_tag;
	assign value_byte    = head.value_byte;
	assign message_valid = head.message_valid;
	assign message_type  = head.message_type;
	assign error_code    = head.error_code;
	assign tail_dropped  = head.tail_dropped;
	assign run_last      = head.run_last;

endmodule
`default_nettype wire

FILE: tb/fix_tag_value_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fix_tag_value_parser_tb
// Self-checking bench for the tag=value parser. Message bytes go in through
// the valid/stall channel; a scoreboard parses each accepted beat on its own
// and checks every result beat, field by field, in order. Both sides idle in
// random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module fix_tag_value_parser_tb;
	import ftvp_pkg::*;

	localparam int unsigned MAX_TAG        = 999999;
	localparam int          FIX_BEGIN_TAG  = 8;
	localparam int          FIX_LENGTH_TAG = 9;
	localparam int          FIX_TYPE_TAG   = 35;
	localparam int unsigned LONG_HOLD      = 80;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned REPORT_LIMIT   = 10;

	localparam logic [7:0] ASC_SOH   = 8'h01;
	localparam logic [7:0] ASC_SPACE = 8'h20;
	localparam logic [7:0] ASC_TAB   = 8'h09;
	localparam logic [7:0] ASC_CR    = 8'h0D;
	localparam logic [7:0] ASC_PLUS  = 8'h2B;
	localparam logic [7:0] ASC_MINUS = 8'h2D;
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_NINE  = 8'h39;
	localparam logic [7:0] ASC_EQUAL = 8'h3D;

	typedef enum int {TAG_GOOD, TAG_OVER, TAG_BROKEN} tag_style_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     byte_valid = 1'b0;
	logic                     byte_stall;
	logic [7:0]               data_byte = 8'h00;
	logic                     end_of_message = 1'b0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic [1:0]               kind;
	logic signed [FTAG_W-1:0] field_tag;
	logic [7:0]               value_byte;
	logic                     message_valid;
	logic [7:0]               message_type;
	logic [1:0]               error_code;
	logic                     tail_dropped;
	logic                     run_last;

	fix_tag_value_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.field_tag      (field_tag),
		.value_byte     (value_byte),
		.message_valid  (message_valid),
		.message_type   (message_type),
		.error_code     (error_code),
		.tail_dropped   (tail_dropped),
		.run_last       (run_last)
	);

	class field_scoreboard;
		phase_t           phase;
		logic [TAG_W-1:0] tag_mag;
		logic             tag_neg;
		logic [1:0]       tag_bad;
		logic [7:0]       value_first;
		logic             value_nonempty;
		logic             seen_begin;
		logic             seen_length;
		logic             seen_type;
		logic [7:0]       type_reg;
		logic [1:0]       err;
		result_t          pending_results[$];
		int unsigned      mismatches;

		function new();
			type_reg = 8'h00;
			mismatches = 0;
			clear_message();
		endfunction

		function void clear_field();
			tag_mag = '0;
			tag_neg = 1'b0;
			tag_bad = ERR_NONE;
			value_first = 8'h00;
			value_nonempty = 1'b0;
		endfunction

		function void clear_message();
			clear_field();
			phase = PH_START;
			seen_begin = 1'b0;
			seen_length = 1'b0;
			seen_type = 1'b0;
			err = ERR_NONE;
		endfunction

		function logic signed [FTAG_W-1:0] signed_tag();
			logic signed [FTAG_W-1:0] m;
			m = {1'b0, tag_mag};
			return tag_neg ? -m : m;
		endfunction

		function bit is_space(logic [7:0] c);
			return c == ASC_SPACE || (c >= ASC_TAB && c <= ASC_CR);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= ASC_ZERO && c <= ASC_NINE;
		endfunction

		// saturate just past the limit and flag the tag
		function void add_digit(logic [7:0] c);
			int unsigned acc;
			acc = 32'(tag_mag) * 10 + 32'(c - ASC_ZERO);
			if (acc > MAX_TAG) begin
				tag_mag = TAG_W'(MAX_TAG + 1);
				tag_bad = ERR_LIMIT;
			end else begin
				tag_mag = acc[TAG_W-1:0];
			end
		endfunction

		function void queue_result(logic [1:0] k, logic signed [FTAG_W-1:0] t,
		                           logic [7:0] vb, logic valid, logic tail);
			result_t r;
			r.kind = k;
			r.field_tag = t;
			r.value_byte = vb;
			r.message_valid = valid;
			r.message_type = type_reg;
			r.error_code = err;
			r.tail_dropped = tail;
			r.run_last = 1'b0;
			pending_results.push_back(r);
		endfunction

		// advance the parser by one accepted beat and queue what it produces
		function void parse_byte(logic [7:0] c, logic eom);
			int unsigned              start_count;
			logic signed [FTAG_W-1:0] t;
			logic                     valid;
			logic                     tail;
			start_count = pending_results.size();
			case (phase)
			PH_START, PH_SPACE: begin
				if (c == ASC_EQUAL) begin
					tag_bad = ERR_MALFORMED;
					phase = PH_VALUE;
				end else if (is_space(c)) begin
					phase = PH_SPACE;
				end else if (c == ASC_PLUS || c == ASC_MINUS) begin
					tag_neg = (c == ASC_MINUS);
					phase = PH_SIGN;
				end else if (is_digit(c)) begin
					add_digit(c);
					phase = PH_DIGITS;
				end else begin
					tag_bad = ERR_MALFORMED;
					phase = PH_IGNORE;
				end
			end
			PH_SIGN: begin
				if (c == ASC_EQUAL) begin
					tag_bad = ERR_MALFORMED;
					phase = PH_VALUE;
				end else if (is_digit(c)) begin
					add_digit(c);
					phase = PH_DIGITS;
				end else begin
					tag_bad = ERR_MALFORMED;
					phase = PH_IGNORE;
				end
			end
			PH_DIGITS: begin
				if (c == ASC_EQUAL)
					phase = PH_VALUE;
				else if (is_digit(c))
					add_digit(c);
				else
					phase = PH_IGNORE;
			end
			PH_IGNORE: begin
				if (c == ASC_EQUAL)
					phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (c == ASC_SOH) begin
					t = '0;
					if (tag_bad != ERR_NONE) begin
						err = tag_bad;
					end else begin
						t = signed_tag();
						if (t == FIX_BEGIN_TAG)
							seen_begin = 1'b1;
						if (t == FIX_LENGTH_TAG)
							seen_length = 1'b1;
						if (t == FIX_TYPE_TAG) begin
							seen_type = 1'b1;
							if (value_nonempty)
								type_reg = value_first;
						end
					end
					queue_result(KIND_FIELD, t, 8'h00, 1'b0, 1'b0);
					clear_field();
					phase = (err != ERR_NONE) ? PH_SKIP : PH_START;
				end else begin
					if (!value_nonempty) begin
						value_first = c;
						value_nonempty = 1'b1;
					end
					// drop value bytes of a tag already known to be bad
					if (tag_bad == ERR_NONE)
						queue_result(KIND_VALUE, signed_tag(), c, 1'b0, 1'b0);
				end
			end
			default: phase = PH_SKIP;
			endcase

			if (eom) begin
				valid = err == ERR_NONE && seen_begin && seen_length && seen_type;
				tail = phase != PH_START && phase != PH_SKIP;
				queue_result(KIND_MESSAGE, '0, 8'h00, valid, tail);
				clear_message();
			end

			if (pending_results.size() > start_count)
				pending_results[pending_results.size() - 1].run_last = 1'b1;
		endfunction

		function string describe(result_t r);
			return {$sformatf("kind %0d tag %0d byte %02h valid %0d ",
					r.kind, r.field_tag, r.value_byte, r.message_valid),
				$sformatf("type %02h error %0d tail %0d last %0d",
					r.message_type, r.error_code, r.tail_dropped, r.run_last)};
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: unexpected result beat: %s", describe(got));
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.field_tag !== want.field_tag ||
			    got.value_byte !== want.value_byte || got.message_valid !== want.message_valid ||
			    got.message_type !== want.message_type || got.error_code !== want.error_code ||
			    got.tail_dropped !== want.tail_dropped || got.run_last !== want.run_last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: result beat differs at %0t", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	field_scoreboard board;
	logic [7:0]      msg_q[$];
	bit              idle_on = 1'b0;
	int unsigned     bytes_sent = 0;
	int unsigned     results_checked = 0;
	int unsigned     stall_left = 0;
	bit              long_hold_done = 1'b0;
	int unsigned     quiet_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] space_char();
		return ($urandom_range(0, 2) == 0) ? ASC_SPACE : 8'($urandom_range(ASC_TAB, ASC_CR));
	endfunction

	function automatic logic [7:0] any_byte_but(logic [7:0] skip);
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == skip);
		return c;
	endfunction

	function automatic logic [7:0] sign_char();
		return $urandom_range(0, 1) ? ASC_PLUS : ASC_MINUS;
	endfunction

	// append one tag=value<SOH> field; a negative tag means pick one at random
	function automatic void push_field(tag_style_t style, int tag);
		int unsigned number;
		string       digits;
		if (style == TAG_BROKEN) begin
			case ($urandom_range(0, 4))
			0: ;
			1: msg_q.push_back(sign_char());
			2: msg_q.push_back(8'($urandom_range(8'h41, 8'h7A)));
			3: begin
				msg_q.push_back(space_char());
				msg_q.push_back(8'h78);
			end
			default: begin
				msg_q.push_back(ASC_MINUS);
				msg_q.push_back(space_char());
			end
			endcase
		end else begin
			if (tag < 0) begin
				case ($urandom_range(0, 5))
				0: tag = MAX_TAG;
				1: tag = 0;
				2, 3: tag = $urandom_range(1, 99);
				4: tag = $urandom_range(100, MAX_TAG);
				default: tag = $urandom_range(0, 1) ? FIX_TYPE_TAG : FIX_BEGIN_TAG;
				endcase
			end
			number = tag;
			if (style == TAG_OVER) begin
				case ($urandom_range(0, 2))
				0: number = MAX_TAG + 1;
				1: number = $urandom_range(MAX_TAG + 1, 9999999);
				default: number = $urandom_range(100000000, 32'hFFFFFFFF);
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2)) msg_q.push_back(space_char());
			if ($urandom_range(0, 6) == 0)
				msg_q.push_back(sign_char());
			if ($urandom_range(0, 7) == 0)
				msg_q.push_back(ASC_ZERO);
			digits = $sformatf("%0d", number);
			foreach (digits[k])
				msg_q.push_back(digits[k]);
			// trailing text after the digits is ignored, SOH included
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2)) msg_q.push_back(any_byte_but(ASC_EQUAL));
		end
		msg_q.push_back(ASC_EQUAL);
		repeat ($urandom_range(0, 5)) msg_q.push_back(any_byte_but(ASC_SOH));
		msg_q.push_back(ASC_SOH);
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic eom);
		byte_valid <= 1'b1;
		data_byte <= value;
		end_of_message <= eom;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		board.parse_byte(value, eom);
		bytes_sent++;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			data_byte <= 8'($urandom);
			end_of_message <= 1'($urandom);
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send_message();
		foreach (msg_q[k])
			send_byte(msg_q[k], k == msg_q.size() - 1);
		msg_q.delete();
	endtask

	task automatic send_random_message();
		int unsigned fields;
		int unsigned bad_at;
		bit          header;
		fields = $urandom_range(1, 7);
		bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, fields - 1) : fields;
		header = $urandom_range(0, 4) != 0;
		if ($urandom_range(0, 9) == 0) begin
			// loose bytes, biased toward the delimiters
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 3))
				0: msg_q.push_back(ASC_SOH);
				1: msg_q.push_back(ASC_EQUAL);
				default: msg_q.push_back(8'($urandom));
				endcase
			end
		end else begin
			for (int i = 0; i < fields; i++) begin
				if (i == bad_at)
					push_field($urandom_range(0, 1) ? TAG_OVER : TAG_BROKEN, -1);
				else if (header && i < 3)
					push_field(TAG_GOOD, i == 0 ? FIX_BEGIN_TAG :
						(i == 1 ? FIX_LENGTH_TAG : FIX_TYPE_TAG));
				else
					push_field(TAG_GOOD, -1);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom));
		end
		send_message();
	endtask

	// receiver: check result beats and drive result_stall in bursts
	always @(posedge clk) begin : result_side
		result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.kind = kind;
			got.field_tag = field_tag;
			got.value_byte = value_byte;
			got.message_valid = message_valid;
			got.message_type = message_type;
			got.error_code = error_code;
			got.tail_dropped = tail_dropped;
			got.run_last = run_last;
			board.check_result(got);
			results_checked++;
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (!long_hold_done && results_checked >= 250) begin
			// hold long enough for the result queue to back up into the input
			stall_left = LONG_HOLD;
			long_hold_done = 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18);
		end
		result_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin : watchdog
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 35=A, 8=<FF>, 9=<00>, then an empty 35 that keeps type A
		msg_q = '{8'h33, 8'h35, ASC_EQUAL, 8'h41, ASC_SOH,
		          8'h38, ASC_EQUAL, 8'hFF, ASC_SOH,
		          8'h39, ASC_EQUAL, 8'h00, ASC_SOH,
		          8'h33, 8'h35, ASC_EQUAL, ASC_SOH};
		send_message();
		// tab, sign, digits, ignored text and an empty value; then a field with
		// no tag at all, and a skipped byte after the error
		msg_q = '{ASC_TAB, ASC_MINUS, 8'h37, 8'h78, ASC_EQUAL, ASC_SOH,
		          ASC_EQUAL, ASC_SOH, 8'h71};
		send_message();
		// lone digit left unfinished at end of message
		msg_q = '{8'h35};
		send_message();

		while (bytes_sent < 1050) begin
			idle_on = $urandom_range(0, 4) != 0;
			send_random_message();
		end
		idle_on = 1'b0;
		while (bytes_sent < 1200)
			send_random_message();
		byte_valid <= 1'b0;

		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ftvp_pkg.sv
sv/ftvp_step.sv
sv/ftvp_outq.sv
sv/fix_tag_value_parser.sv
tb/fix_tag_value_parser_tb.sv
